>>> design/dpes_pkg.sv
// ----------------------------------------------------------------------------
// Degree-preserving edge swap package
// Shared field widths, item kinds, result status codes and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package dpes_pkg;

  localparam int KIND_W   = 2;
  localparam int INDEX_W  = 10;
  localparam int NODE_W   = 16;
  localparam int COUNT_W  = 11;
  localparam int STATUS_W = 3;
  localparam int TOTAL_W  = 32;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD = 2'd0,
    KIND_SWAP = 2'd1,
    KIND_READ = 2'd2
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_LOADED  = 3'd0,
    ST_SWAPPED = 3'd1,
    ST_LOOP    = 3'd2,
    ST_DUP     = 3'd3,
    ST_READ    = 3'd4,
    ST_RANGE   = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ_WAIT,
    S_SWAP_FIRST,
    S_SWAP_SECOND,
    S_SCAN,
    S_WRITE_FIRST,
    S_WRITE_SECOND
  } state_t;

endpackage

`default_nettype wire

>>> design/degree_preserving_edge_swap_core.sv
// ----------------------------------------------------------------------------
// Degree-preserving edge swap core
// Directed edge table with load, read and a rewiring swap of an edge pair.
// ----------------------------------------------------------------------------
// Channel   Signals                                             Direction
// command   start, busy, kind, first_index, second_index,       in
//           source_node, target_node
// result    done, status, edge_source_out, edge_target_out,     out
//           rejected_total
// config    cfg_write, cfg_data (edge_count)                    in
//
// A load or out-of-range command gives its result in the cycle after the beat;
// a read passes through S_READ_WAIT, a swap rejected as a self-loop through
// S_SWAP_FIRST and S_SWAP_SECOND. The duplicate scan checks the stored edges
// below min(edge_count, MAX_EDGES): the single read port of the edge memory
// scans one per cycle. Reset clears the sequencer, strobe, edge_count and the
// reject counter; the edge memory is not cleared. Results cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module degree_preserving_edge_swap_core #(
  parameter int MAX_EDGES = 1024,
  parameter int NODE_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [dpes_pkg::KIND_W-1:0]   kind,
  input  wire logic [dpes_pkg::INDEX_W-1:0]  first_index,
  input  wire logic [dpes_pkg::INDEX_W-1:0]  second_index,
  input  wire logic [dpes_pkg::NODE_W-1:0]   source_node,
  input  wire logic [dpes_pkg::NODE_W-1:0]   target_node,
  output logic                               done,
  output logic [dpes_pkg::STATUS_W-1:0]      status,
  output logic [dpes_pkg::NODE_W-1:0]        edge_source_out,
  output logic [dpes_pkg::NODE_W-1:0]        edge_target_out,
  output logic [dpes_pkg::TOTAL_W-1:0]       rejected_total,
  input  wire logic                          cfg_write,
  input  wire logic [dpes_pkg::COUNT_W-1:0]  cfg_data
);
  import dpes_pkg::*;

  localparam int AW = $clog2(MAX_EDGES);
  localparam int CW = $clog2(MAX_EDGES + 1);
  localparam int SW = (NODE_BITS < NODE_W) ? NODE_BITS : NODE_W;

  logic [2*SW-1:0]    mem [MAX_EDGES];
  logic [2*SW-1:0]    rd_data;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [2*SW-1:0]    mem_wdata;
  logic [AW-1:0]      mem_raddr;

  state_t             state;
  state_t             state_next;
  logic [COUNT_W-1:0] edge_count;
  logic [TOTAL_W-1:0] counter;
  logic [AW-1:0]      idx1;
  logic [AW-1:0]      idx2;
  logic [AW-1:0]      cnt;
  logic [SW-1:0]      a;
  logic [SW-1:0]      b;
  logic [SW-1:0]      c;
  logic [SW-1:0]      d;

  logic               done_next;
  status_t            status_next;
  logic [SW-1:0]      src_next;
  logic [SW-1:0]      tgt_next;
  logic               reject;
  logic [CW-1:0]      live;
  logic               i1_ok;
  logic               i2_ok;
  logic               i1_live;
  logic               i2_live;
  logic [SW-1:0]      rd_src;
  logic [SW-1:0]      rd_tgt;
  logic               hit;

  assign rd_src  = rd_data[2*SW-1:SW];
  assign rd_tgt  = rd_data[SW-1:0];
  assign live    = (32'(edge_count) < MAX_EDGES) ? CW'(edge_count) : CW'(MAX_EDGES);
  assign i1_ok   = 32'(first_index) < MAX_EDGES;
  assign i1_live = 32'(first_index) < 32'(live);
  assign i2_live = 32'(second_index) < 32'(live);
  assign i2_ok   = i1_live && i2_live;
  assign hit     = (rd_data == {a, d}) || (rd_data == {c, b});

  assign busy           = (state != S_IDLE);
  assign rejected_total = counter;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[mem_raddr];
  end

  always_comb begin
    state_next  = state;
    mem_we      = 1'b0;
    mem_waddr   = idx1;
    mem_wdata   = {a, d};
    mem_raddr   = AW'(first_index);
    done_next   = 1'b0;
    status_next = ST_RANGE;
    src_next    = '0;
    tgt_next    = '0;
    reject      = 1'b0;
    case (state)
      S_IDLE: begin
        if (start) begin
          case (kind)
            KIND_LOAD: begin
              done_next = 1'b1;
              if (i1_ok) begin
                mem_we      = 1'b1;
                mem_waddr   = AW'(first_index);
                mem_wdata   = {SW'(source_node), SW'(target_node)};
                status_next = ST_LOADED;
                src_next    = SW'(source_node);
                tgt_next    = SW'(target_node);
              end
            end
            KIND_READ: begin
              if (i1_ok) begin
                state_next = S_READ_WAIT;
              end else begin
                done_next = 1'b1;
              end
            end
            KIND_SWAP: begin
              if (i2_ok) begin
                state_next = S_SWAP_FIRST;
              end else begin
                done_next = 1'b1;
              end
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end
      S_READ_WAIT: begin
        done_next   = 1'b1;
        status_next = ST_READ;
        src_next    = rd_src;
        tgt_next    = rd_tgt;
        state_next  = S_IDLE;
      end
      S_SWAP_FIRST: begin
        mem_raddr  = idx2;
        state_next = S_SWAP_SECOND;
      end
      S_SWAP_SECOND: begin
        mem_raddr = '0;
        if ((a == rd_tgt) || (b == rd_src)) begin
          done_next   = 1'b1;
          status_next = ST_LOOP;
          src_next    = a;
          tgt_next    = b;
          reject      = 1'b1;
          state_next  = S_IDLE;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        mem_raddr = cnt + 1'b1;
        if (hit) begin
          done_next   = 1'b1;
          status_next = ST_DUP;
          src_next    = a;
          tgt_next    = b;
          reject      = 1'b1;
          state_next  = S_IDLE;
        end else if (CW'(cnt) == live - 1'b1) begin
          state_next = S_WRITE_FIRST;
        end
      end
      S_WRITE_FIRST: begin
        mem_we     = 1'b1;
        mem_waddr  = idx1;
        mem_wdata  = {a, d};
        state_next = S_WRITE_SECOND;
      end
      S_WRITE_SECOND: begin
        mem_we      = 1'b1;
        mem_waddr   = idx2;
        mem_wdata   = {c, b};
        done_next   = 1'b1;
        status_next = ST_SWAPPED;
        src_next    = a;
        tgt_next    = d;
        state_next  = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      done       <= 1'b0;
      counter    <= '0;
      edge_count <= '0;
    end else begin
      state <= state_next;
      done  <= done_next;
      if (reject && (counter != '1)) begin
        counter <= counter + 1'b1;
      end
      if (cfg_write) begin
        edge_count <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    status          <= status_next;
    edge_source_out <= NODE_W'(src_next);
    edge_target_out <= NODE_W'(tgt_next);
    if (state == S_IDLE) begin
      idx1 <= AW'(first_index);
      idx2 <= AW'(second_index);
    end
    if (state == S_SWAP_FIRST) begin
      a <= rd_src;
      b <= rd_tgt;
    end
    if (state == S_SWAP_SECOND) begin
      c   <= rd_src;
      d   <= rd_tgt;
      cnt <= '0;
    end else if (state == S_SCAN) begin
      cnt <= cnt + 1'b1;
    end
  end

endmodule

`default_nettype wire
